/* sv/hfr_pkg.sv */
package hfr_pkg;

  typedef enum logic [4:0] {
    PH_METHOD     = 5'd0,
    PH_URI        = 5'd1,
    PH_VERSION    = 5'd2,
    PH_REQ_LF     = 5'd3,
    PH_LINE_START = 5'd4,
    PH_KEY        = 5'd5,
    PH_COLON      = 5'd6,
    PH_VAL        = 5'd7,
    PH_VAL_LF     = 5'd8,
    PH_HDR_LF     = 5'd9,
    PH_BODY       = 5'd10,
    PH_CSIZE      = 5'd11,
    PH_CSIZE_LF   = 5'd12,
    PH_CDATA      = 5'd13,
    PH_CDATA_CR   = 5'd14,
    PH_CDATA_LF   = 5'd15,
    PH_FIN_CR     = 5'd16,
    PH_FIN_LF     = 5'd17
  } phase_e;

  typedef enum logic [2:0] {
    TAG_METHOD  = 3'd0,
    TAG_URI     = 3'd1,
    TAG_VERSION = 3'd2,
    TAG_KEY     = 3'd3,
    TAG_VALUE   = 3'd4,
    TAG_BODY    = 3'd5,
    TAG_DELIM   = 3'd6
  } tag_e;

  typedef struct packed {
    tag_e byte_part;
    logic header_start;
    logic header_done;
    logic request_done;
    logic frame_error;
  } result_t;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [4:0] CL_LEN  = 5'd14;
  localparam logic [4:0] TE_LEN  = 5'd17;
  localparam logic [4:0] POS_MAX = 5'd31;

  // "content-length", one character per position
  function automatic logic [7:0] cl_char(input logic [4:0] pos);
    logic [7:0] ch;
    case (pos)
      5'd0:    ch = "c";
      5'd1:    ch = "o";
      5'd2:    ch = "n";
      5'd3:    ch = "t";
      5'd4:    ch = "e";
      5'd5:    ch = "n";
      5'd6:    ch = "t";
      5'd7:    ch = "-";
      5'd8:    ch = "l";
      5'd9:    ch = "e";
      5'd10:   ch = "n";
      5'd11:   ch = "g";
      5'd12:   ch = "t";
      5'd13:   ch = "h";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "transfer-encoding", one character per position
  function automatic logic [7:0] te_char(input logic [4:0] pos);
    logic [7:0] ch;
    case (pos)
      5'd0:    ch = "t";
      5'd1:    ch = "r";
      5'd2:    ch = "a";
      5'd3:    ch = "n";
      5'd4:    ch = "s";
      5'd5:    ch = "f";
      5'd6:    ch = "e";
      5'd7:    ch = "r";
      5'd8:    ch = "-";
      5'd9:    ch = "e";
      5'd10:   ch = "n";
      5'd11:   ch = "c";
      5'd12:   ch = "o";
      5'd13:   ch = "d";
      5'd14:   ch = "i";
      5'd15:   ch = "n";
      5'd16:   ch = "g";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= "A" && c <= "Z") begin
      r = c | 8'h20;
    end
    return r;
  endfunction

  function automatic logic [4:0] pos_inc(input logic [4:0] pos);
    return (pos == POS_MAX) ? pos : pos + 5'd1;
  endfunction

endpackage

/* sv/hfr_out_reg.sv */
module hfr_out_reg
  import hfr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  result_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  output result_t data_o,
  input  logic    ready_i
);

  logic    valid_q;
  result_t data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

/* sv/hfr_parse_core.sv */
module hfr_parse_core
  import hfr_pkg::*;
#(
  parameter int LEN_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  input  logic [7:0] s_byte_i,
  output logic       s_ready_o,
  output logic       r_valid_o,
  output result_t    r_data_o,
  input  logic       r_ready_i
);

  localparam int SumW = LEN_BITS + 4;

  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  logic                step;

  phase_e              phase_q, phase_d;
  logic [4:0]          pos_q, pos_d;
  logic [1:0]          flags_q, flags_d;
  logic                len_seen_q, len_seen_d;
  logic                chunked_q, chunked_d;
  logic [LEN_BITS-1:0] acc_q, acc_d;
  logic [LEN_BITS-1:0] body_q, body_d;
  logic                err_q, err_d;

  logic                restart;
  logic [7:0]          c;
  logic [7:0]          lc;
  logic [4:0]          kpos;
  logic [1:0]          kflags;
  logic                cl_ok, te_ok;
  logic                is_digit;
  logic [3:0]          digit;
  logic [SumW-1:0]     dec_sum;
  logic                dec_ovf;
  logic                hex_ok;
  logic [3:0]          hex_nib;
  logic                hex_ovf;
  logic [LEN_BITS-1:0] body_dec;
  result_t             res;

  assign step      = in_valid_q && r_ready_i;
  assign s_ready_o = !in_valid_q || r_ready_i;
  assign r_valid_o = in_valid_q;
  assign r_data_o  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_ready_o) begin
      in_valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      in_byte_q <= s_byte_i;
    end
  end

  // key matching starts over on the first byte of a header line
  assign c      = in_byte_q;
  assign lc     = fold_case(c);
  assign kpos   = (phase_q == PH_LINE_START) ? 5'd0 : pos_q;
  assign kflags = (phase_q == PH_LINE_START) ? 2'b11 : flags_q;
  assign cl_ok  = (kpos < CL_LEN) && (lc == cl_char(kpos));
  assign te_ok  = (kpos < TE_LEN) && (lc == te_char(kpos));

  // decimal digit: acc * 10 + d, overflow when it leaves LEN_BITS
  assign is_digit = (c >= "0") && (c <= "9");
  assign digit    = 4'(c - "0");
  assign dec_sum  = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
                  + {{LEN_BITS{1'b0}}, digit};
  assign dec_ovf  = |dec_sum[SumW-1:LEN_BITS];

  always_comb begin
    hex_ok  = 1'b1;
    hex_nib = 4'd0;
    if (c >= "0" && c <= "9") begin
      hex_nib = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      hex_nib = 4'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      hex_nib = 4'(c - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign hex_ovf  = |acc_q[LEN_BITS-1:LEN_BITS-4];
  assign body_dec = body_q - {{(LEN_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    flags_d    = flags_q;
    len_seen_d = len_seen_q;
    chunked_d  = chunked_q;
    acc_d      = acc_q;
    body_d     = body_q;
    err_d      = err_q;
    restart    = 1'b0;
    res        = '{byte_part: TAG_DELIM, header_start: 1'b0, header_done: 1'b0,
                   request_done: 1'b0, frame_error: 1'b0};

    if (!err_q) begin
      case (phase_q)
        PH_METHOD: begin
          res.header_start = 1'b1;
          if (c == CH_SPACE) phase_d = PH_URI;
          else res.byte_part = TAG_METHOD;
        end
        PH_URI: begin
          if (c == CH_SPACE) phase_d = PH_VERSION;
          else res.byte_part = TAG_URI;
        end
        PH_VERSION: begin
          if (c == CH_CR) phase_d = PH_REQ_LF;
          else res.byte_part = TAG_VERSION;
        end
        PH_REQ_LF, PH_VAL_LF: begin
          if (c == CH_LF) phase_d = PH_LINE_START;
          else err_d = 1'b1;
        end
        PH_LINE_START, PH_KEY: begin
          if (phase_q == PH_LINE_START && c == CH_CR) begin
            phase_d = PH_HDR_LF;
          end else if (c == CH_COLON) begin
            flags_d[0] = kflags[0] && (kpos == CL_LEN);
            flags_d[1] = kflags[1] && (kpos == TE_LEN);
            if (kflags[0] && (kpos == CL_LEN)) acc_d = '0;
            pos_d   = 5'd0;
            phase_d = PH_COLON;
          end else begin
            flags_d       = kflags & {te_ok, cl_ok};
            pos_d         = pos_inc(kpos);
            phase_d       = PH_KEY;
            res.byte_part = TAG_KEY;
          end
        end
        PH_COLON, PH_VAL: begin
          if (phase_q == PH_COLON && c == CH_SPACE) begin
            phase_d = PH_VAL;
          end else if (c == CH_CR) begin
            if (flags_q[0]) begin
              if (pos_q == 5'd0) err_d = 1'b1;
              else len_seen_d = 1'b1;
            end
            if (flags_q[1]) chunked_d = 1'b1;
            phase_d = PH_VAL_LF;
          end else begin
            phase_d       = PH_VAL;
            res.byte_part = TAG_VALUE;
            if (flags_q[0]) begin
              if (is_digit) begin
                if (dec_ovf) err_d = 1'b1;
                else acc_d = dec_sum[LEN_BITS-1:0];
                pos_d = pos_inc(pos_q);
              end else begin
                err_d = 1'b1;
              end
            end
          end
        end
        PH_HDR_LF: begin
          if (c == CH_LF) begin
            res.header_done = 1'b1;
            if (len_seen_q) begin
              if (acc_q == '0) begin
                res.request_done = 1'b1;
                restart          = 1'b1;
              end else begin
                body_d  = acc_q;
                phase_d = PH_BODY;
              end
            end else if (chunked_q) begin
              acc_d   = '0;
              pos_d   = 5'd0;
              phase_d = PH_CSIZE;
            end else begin
              res.request_done = 1'b1;
              restart          = 1'b1;
            end
          end else begin
            err_d = 1'b1;
          end
        end
        PH_BODY: begin
          res.byte_part = TAG_BODY;
          body_d        = body_dec;
          if (body_dec == '0) begin
            res.request_done = 1'b1;
            restart          = 1'b1;
          end
        end
        PH_CSIZE: begin
          if (c == CH_CR) begin
            phase_d = PH_CSIZE_LF;
          end else if (!hex_ok || hex_ovf) begin
            err_d = 1'b1;
          end else begin
            acc_d = {acc_q[LEN_BITS-5:0], hex_nib};
            pos_d = pos_inc(pos_q);
          end
        end
        PH_CSIZE_LF: begin
          if (c != CH_LF || pos_q == 5'd0) begin
            err_d = 1'b1;
          end else if (acc_q == '0) begin
            phase_d = PH_FIN_CR;
          end else begin
            body_d  = acc_q;
            phase_d = PH_CDATA;
          end
        end
        PH_CDATA: begin
          res.byte_part = TAG_BODY;
          body_d        = body_dec;
          if (body_dec == '0) phase_d = PH_CDATA_CR;
        end
        PH_CDATA_CR: begin
          if (c == CH_CR) phase_d = PH_CDATA_LF;
          else err_d = 1'b1;
        end
        PH_CDATA_LF: begin
          if (c == CH_LF) begin
            acc_d   = '0;
            pos_d   = 5'd0;
            phase_d = PH_CSIZE;
          end else begin
            err_d = 1'b1;
          end
        end
        PH_FIN_CR: begin
          if (c == CH_CR) phase_d = PH_FIN_LF;
          else err_d = 1'b1;
        end
        PH_FIN_LF: begin
          if (c == CH_LF) begin
            res.request_done = 1'b1;
            restart          = 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end
        default: begin
          err_d = 1'b1;
        end
      endcase

      if (restart) begin
        phase_d    = PH_METHOD;
        pos_d      = 5'd0;
        flags_d    = 2'b11;
        len_seen_d = 1'b0;
        chunked_d  = 1'b0;
        acc_d      = '0;
        body_d     = '0;
      end
    end

    res.frame_error = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_METHOD;
      pos_q      <= 5'd0;
      flags_q    <= 2'b11;
      len_seen_q <= 1'b0;
      chunked_q  <= 1'b0;
      acc_q      <= '0;
      body_q     <= '0;
      err_q      <= 1'b0;
    end else if (step) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      flags_q    <= flags_d;
      len_seen_q <= len_seen_d;
      chunked_q  <= chunked_d;
      acc_q      <= acc_d;
      body_q     <= body_d;
      err_q      <= err_d;
    end
  end

endmodule

/* sv/http_request_framer.sv */
// a byte passes the input register, then the output register, before the master side sees it
// throughput: one byte per cycle, sustained while the master side keeps taking
// the rate is set by the single registered pass of the parse state update
// reset: asynchronous active low, returns the parser to the method phase and
// clears the sticky parse error and both stage valids
module http_request_framer
  import hfr_pkg::*;
#(
  parameter int LEN_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // slave side: raw request stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] stream_byte
  // master side: one tagged result per byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [2:0] byte_part, [7:3] zero
  output logic [2:0] m_axis_tuser,   // [0] header_start, [1] header_done, [2] frame_error
  output logic       m_axis_tlast    // request_done
);

  // result of the parse pass on its way into the output register
  logic    res_valid;
  logic    res_ready;
  result_t res_data;
  result_t out_data;

  // input register, parse state and the next-state logic for one byte
  hfr_parse_core #(
    .LEN_BITS (LEN_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_byte_i  (s_axis_tdata),
    .s_ready_o (s_axis_tready),
    .r_valid_o (res_valid),
    .r_data_o  (res_data),
    .r_ready_i (res_ready)
  );

  // output register; loads whenever it is empty or being drained, so a
  // waiting result never blocks the next byte for more than the stall itself
  hfr_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (res_valid),
    .data_i  (res_data),
    .ready_o (res_ready),
    .valid_o (m_axis_tvalid),
    .data_o  (out_data),
    .ready_i (m_axis_tready)
  );

  // field packing onto the master side
  assign m_axis_tdata = {5'b0, out_data.byte_part};
  assign m_axis_tuser = {out_data.frame_error, out_data.header_done, out_data.header_start};
  assign m_axis_tlast = out_data.request_done;

endmodule

/* sv/hfr_checker.sv */
module hfr_checker
  import hfr_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  logic err_seen_q;
  logic in_txn;

  assign in_txn = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser[2]) begin
      err_seen_q <= 1'b1;
    end
  end

  // once an error went out, every later result is a bare error delimiter
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && err_seen_q |->
      m_axis_tuser[2] && !m_axis_tlast && (m_axis_tuser[1:0] == 2'b00)
      && (m_axis_tdata[2:0] == TAG_DELIM))
    else $error("result after a parse error is not a bare error delimiter");

  // method bytes are method or delimiter, never end headers or a request
  a_start_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      ((m_axis_tdata[2:0] == TAG_METHOD) || (m_axis_tdata[2:0] == TAG_DELIM))
      && !m_axis_tuser[1] && !m_axis_tlast)
    else $error("header_start with a wrong tag or flag");

  // the blank line that ends the headers is a delimiter
  a_done_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata[2:0] == TAG_DELIM))
    else $error("header_done on a byte that is not a delimiter");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a byte accepted into an empty pipeline is answered after the input and output registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_txn && !m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready) |=>
      ##1 m_axis_tvalid)
    else $error("result missing two cycles after the byte");

endmodule

bind http_request_framer hfr_checker u_hfr_checker (.*);
